>>> sv/tlbpt_pkg.sv
// Shared widths and constants for the TLB page translation block.
// Used by the channel interfaces and by the top level; depends on nothing.
package tlbpt_pkg;

  localparam int VA_WIDTH    = 16;  // virtual and physical address width
  localparam int FRAME_WIDTH = 8;   // physical frame number width
  localparam int COUNT_WIDTH = 16;  // saturating hit and fault totals
  localparam int FREE_WIDTH  = 9;   // next-free-frame counter, wraps modulo 512

  // Fixed-point shift of the reciprocal used to reduce the page number
  // modulo the page table size. It is exact for page numbers below 4096.
  localparam int RECIP_SHIFT = 24;

endpackage

>>> sv/tlbpt_if.sv
// Valid/ready channel interfaces for the TLB page translation block.
// Depends on tlbpt_pkg for the payload widths.

interface tlbpt_va_if;
  logic                             valid;
  logic                             ready;
  logic [tlbpt_pkg::VA_WIDTH-1:0]   virtual_address;

  modport source (output valid, output virtual_address, input ready);
  modport sink   (input valid, input virtual_address, output ready);
endinterface

interface tlbpt_pa_if;
  logic                              valid;
  logic                              ready;
  logic [tlbpt_pkg::VA_WIDTH-1:0]    physical_address;
  logic [tlbpt_pkg::FRAME_WIDTH-1:0] frame_number;
  logic                              tlb_hit;
  logic                              page_fault;
  logic [tlbpt_pkg::COUNT_WIDTH-1:0] hit_total;
  logic [tlbpt_pkg::COUNT_WIDTH-1:0] fault_total;

  modport source (output valid, output physical_address, output frame_number,
                  output tlb_hit, output page_fault, output hit_total,
                  output fault_total, input ready);
  modport sink   (input valid, input physical_address, input frame_number,
                  input tlb_hit, input page_fault, input hit_total,
                  input fault_total, output ready);
endinterface

>>> sv/tlbpt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the page table of the TLB page translation block.
module tlbpt_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/tlb_page_translate_core.sv
// Top level of the TLB page translation block: fully associative TLB in
// flip-flops, page table in tlbpt_ram. Depends on tlbpt_pkg, tlbpt_if and tlbpt_ram.
//
//   Channel  Dir  Payload                                          Transaction
//   vaddr    in   virtual_address                                  valid & ready
//   result   out  physical_address, frame_number, tlb_hit,         valid & ready
//                 page_fault, hit_total, fault_total
//
// One address is taken per cycle while result does not stall and no clearing
// pass runs; it passes through stage A (page reduction), stage B (page table
// read and TLB lookup) and the result register. After reset a clearing pass
// writes every page table entry, one per cycle, and vaddr.ready stays low until the pass ends.
// A stall on result backs up through the two internal stages; the stages keep
// filling until both are occupied, then vaddr.ready drops.
module tlb_page_translate_core #(
  parameter int TLB_ENTRIES  = 16,
  parameter int PAGE_COUNT   = 256,
  parameter int OFFSET_WIDTH = 8
) (
  input logic        clk,
  input logic        rst,
  tlbpt_va_if.sink   vaddr,
  tlbpt_pa_if.source result
);

  localparam int VA_W    = tlbpt_pkg::VA_WIDTH;
  localparam int FR_W    = tlbpt_pkg::FRAME_WIDTH;
  localparam int CNT_W   = tlbpt_pkg::COUNT_WIDTH;
  localparam int FREE_W  = tlbpt_pkg::FREE_WIDTH;
  localparam int SHIFT   = tlbpt_pkg::RECIP_SHIFT;
  localparam int PAGE_W  = $clog2(PAGE_COUNT);
  localparam int SLOT_W  = $clog2(TLB_ENTRIES);
  localparam int PX_W    = VA_W - OFFSET_WIDTH + 1;
  localparam int PROD_W  = PX_W + SHIFT + 1;
  localparam int MAP_W   = FR_W + 1;
  localparam longint RECIP = ((64'd1 << SHIFT) + PAGE_COUNT - 1) / PAGE_COUNT;
  localparam logic [VA_W-1:0] OFF_MASK = VA_W'((64'd1 << OFFSET_WIDTH) - 64'd1);

  // Page table clearing pass
  logic              clearing;
  logic [PAGE_W-1:0] clr_idx;

  // Input side: quotient of the page number by PAGE_COUNT
  logic [PX_W-1:0]   in_px;
  logic [PROD_W-1:0] in_prod;
  logic [PX_W-1:0]   in_quot;
  logic              in_fire;

  // Stage A: remainder, page table read address
  logic              a_valid;
  logic [VA_W-1:0]   a_va;
  logic [PX_W-1:0]   a_quot;
  logic [PX_W-1:0]   a_px;
  logic [PX_W-1:0]   a_rem;
  logic [PAGE_W-1:0] a_page;
  logic              a_adv;
  logic              a_free;

  // Stage B: TLB lookup and state update
  logic              b_valid;
  logic [VA_W-1:0]   b_va;
  logic [PAGE_W-1:0] b_page;
  logic              b_adv;
  logic              b_free;
  logic [MAP_W-1:0]  map_rdata;
  logic              map_known;
  logic              hit;
  logic [FR_W-1:0]   hit_frame;
  logic              fault;
  logic [FR_W-1:0]   frame;
  logic [VA_W-1:0]   pa;

  // TLB and running state
  logic [PAGE_W-1:0] tlb_tag   [TLB_ENTRIES];
  logic [FR_W-1:0]   tlb_frame [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_valid;
  logic [SLOT_W-1:0] fill_slot;
  logic [SLOT_W-1:0] fill_slot_next;
  logic [FREE_W-1:0] next_free;
  logic [CNT_W-1:0]  hit_cnt;
  logic [CNT_W-1:0]  hit_cnt_next;
  logic [CNT_W-1:0]  fault_cnt;
  logic [CNT_W-1:0]  fault_cnt_next;

  // Result register
  logic              o_valid;
  logic [VA_W-1:0]   o_pa;
  logic [FR_W-1:0]   o_frame;
  logic              o_hit;
  logic              o_fault;

  // Page table write port
  logic              map_we;
  logic [PAGE_W-1:0] map_waddr;
  logic [MAP_W-1:0]  map_wdata;

  // Handshake chain
  assign b_adv  = b_valid && (!o_valid || result.ready);
  assign b_free = !b_valid || b_adv;
  assign a_adv  = a_valid && b_free;
  assign a_free = !a_valid || a_adv;
  assign vaddr.ready = !clearing && a_free;
  assign in_fire = vaddr.valid && vaddr.ready;

  // The page number is reduced modulo PAGE_COUNT with an exact reciprocal
  // multiply here and one constant multiply and subtract in stage A.
  assign in_px   = PX_W'(vaddr.virtual_address >> OFFSET_WIDTH);
  assign in_prod = PROD_W'(in_px) * PROD_W'(RECIP);
  assign in_quot = in_prod[SHIFT +: PX_W];

  assign a_px   = PX_W'(a_va >> OFFSET_WIDTH);
  assign a_rem  = a_px - PX_W'(32'(a_quot) * PAGE_COUNT);
  assign a_page = PAGE_W'(a_rem);

  // Lowest-numbered valid match wins.
  always_comb begin
    hit       = 1'b0;
    hit_frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid[i] && tlb_tag[i] == b_page) begin
        hit       = 1'b1;
        hit_frame = tlb_frame[i];
      end
    end
  end

  // The page table read for an item can coincide with the write by the item
  // ahead of it. Only a TLB miss looks at the read data, and a page just
  // written is also the newest TLB entry, so that case always hits.
  assign map_known = map_rdata[FR_W];
  assign fault     = !hit && !map_known;
  assign frame     = hit ? hit_frame :
                     map_known ? map_rdata[FR_W-1:0] : next_free[FR_W-1:0];
  assign pa = VA_W'((32'(frame) << OFFSET_WIDTH) | 32'(b_va & OFF_MASK));

  assign hit_cnt_next   = (hit && hit_cnt != '1) ? hit_cnt + 1'b1 : hit_cnt;
  assign fault_cnt_next = (fault && fault_cnt != '1) ? fault_cnt + 1'b1 : fault_cnt;
  assign fill_slot_next = (fill_slot == SLOT_W'(TLB_ENTRIES - 1)) ? '0
                                                                    : fill_slot + 1'b1;

  assign map_we    = clearing || (b_adv && fault);
  assign map_waddr = clearing ? clr_idx : b_page;
  assign map_wdata = clearing ? '0 : {1'b1, frame};

  tlbpt_ram #(
    .WIDTH (MAP_W),
    .DEPTH (PAGE_COUNT)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (a_adv),
    .raddr (a_page),
    .rdata (map_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_idx   <= '0;
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      o_valid   <= 1'b0;
      tlb_valid <= '0;
      fill_slot <= '0;
      next_free <= '0;
      hit_cnt   <= '0;
      fault_cnt <= '0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == PAGE_W'(PAGE_COUNT - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (a_free) begin
        a_valid <= in_fire;
      end
      if (b_free) begin
        b_valid <= a_adv;
      end
      if (b_adv) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
      if (b_adv) begin
        hit_cnt   <= hit_cnt_next;
        fault_cnt <= fault_cnt_next;
        if (fault) begin
          next_free <= next_free + 1'b1;
        end
        if (!hit) begin
          tlb_valid[fill_slot] <= 1'b1;
          fill_slot            <= fill_slot_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_va   <= vaddr.virtual_address;
      a_quot <= in_quot;
    end
    if (a_adv) begin
      b_va   <= a_va;
      b_page <= a_page;
    end
    if (b_adv) begin
      o_pa    <= pa;
      o_frame <= frame;
      o_hit   <= hit;
      o_fault <= fault;
      if (!hit) begin
        tlb_tag[fill_slot]   <= b_page;
        tlb_frame[fill_slot] <= frame;
      end
    end
  end

  assign result.valid            = o_valid;
  assign result.physical_address = o_pa;
  assign result.frame_number     = o_frame;
  assign result.tlb_hit          = o_hit;
  assign result.page_fault       = o_fault;
  assign result.hit_total        = hit_cnt;
  assign result.fault_total      = fault_cnt;

  // A miss leaves the slot it filled valid.
  a_fill_valid: assert property (@(posedge clk) disable iff (rst)
    b_adv && !hit |=> tlb_valid[$past(fill_slot)])
    else $error("TLB slot not valid after fill");

  // Each fault hands out exactly one new frame.
  a_free_step: assert property (@(posedge clk) disable iff (rst)
    b_adv && fault |=> next_free == $past(next_free) + 1'b1)
    else $error("free frame counter did not advance on fault");

  // A result is never both a TLB hit and a fault.
  a_hit_fault: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> !(o_hit && o_fault))
    else $error("result flagged as both hit and fault");

  // The totals never go backwards outside reset.
  a_totals_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> hit_cnt >= $past(hit_cnt) && fault_cnt >= $past(fault_cnt))
    else $error("running total decreased");

  // No work is in flight while the page table is being cleared.
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !a_valid && !b_valid && !o_valid)
    else $error("item in flight during page table clearing");

endmodule
